// ===== hdl/crc_pkg.sv =====
// package for the parameterized crc engine: widths, register indexes and reset values
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package crc_pkg;

   // largest crc register the engine supports
   localparam int MAX_CRC_WIDTH = 64;
   localparam int MIN_CRC_WIDTH = 8;

   // configuration port geometry
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CRC_WIDTH_BITS  = 7;

   // one message byte per request
   localparam int BYTE_BITS = 8;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CRC_WIDTH     = 3'd0,
      CSR_POLYNOMIAL    = 3'd1,
      CSR_INITIAL_VALUE = 3'd2,
      CSR_FINAL_XOR     = 3'd3,
      CSR_REFLECT_MODE  = 3'd4
   } csr_index_type;

   // reset values: standard 32-bit ethernet crc
   localparam logic [CRC_WIDTH_BITS-1:0] RESET_CRC_WIDTH     = 7'd32;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_POLYNOMIAL    = 64'h0000_0000_04C1_1DB7;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_INITIAL_VALUE = 64'h0000_0000_FFFF_FFFF;
   localparam logic [CSR_DATA_WIDTH-1:0] RESET_FINAL_XOR     = 64'h0000_0000_FFFF_FFFF;
   localparam logic                      RESET_REFLECT_MODE  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/crc_if.sv =====
// valid/ready channel interfaces for the crc engine: request bytes and crc results
// depends on crc_pkg for the byte width and the default crc width
`default_nettype none

interface crc_req_if;
   logic                          valid;
   logic                          ready;
   logic [crc_pkg::BYTE_BITS-1:0] data_byte;
   logic                          first_byte;
   logic                          last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

interface crc_rsp_if #(
   parameter int WIDTH = crc_pkg::MAX_CRC_WIDTH
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] crc_result;

   modport source (output valid, output crc_result, input ready);
   modport sink   (input valid, input crc_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/parameterized_crc_engine.sv =====
// parameterized crc engine: configurable width, polynomial, init, final xor, reflection
// depends on crc_pkg and the crc_req_if / crc_rsp_if channel interfaces
// path: a request is registered at accept, then folded; a final byte's crc lands in the result register
// throughput: one byte per cycle unless a final byte waits on an untaken result; the 8-step polynomial
//   fold sits between the request register and the running crc / result registers
// reset: synchronous; pipeline empty, running crc zero, registers at crc-32 settings
`default_nettype none

module parameterized_crc_engine #(
   parameter int MAX_CRC_WIDTH = crc_pkg::MAX_CRC_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   crc_req_if.sink                                  req,
   crc_rsp_if.source                                rsp,
   input  wire logic                                csr_write_enable,
   input  wire logic [crc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [crc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int                                  SHIFT_BITS = $clog2(MAX_CRC_WIDTH);
   localparam int                                  WB         = crc_pkg::CRC_WIDTH_BITS;
   localparam logic [WB-1:0]                       MAX_W      = WB'(MAX_CRC_WIDTH);
   localparam logic [WB-1:0]                       MIN_W      = WB'(crc_pkg::MIN_CRC_WIDTH);
   localparam int                                  NB         = crc_pkg::BYTE_BITS;

   // configuration registers
   logic [WB-1:0]            crc_width_ff;
   logic [MAX_CRC_WIDTH-1:0] polynomial_ff;
   logic [MAX_CRC_WIDTH-1:0] initial_value_ff;
   logic [MAX_CRC_WIDTH-1:0] final_xor_ff;
   logic                     reflect_mode_ff;

   // request register
   logic                     s1_valid_ff;
   logic [NB-1:0]            s1_data_ff;
   logic                     s1_first_ff;
   logic                     s1_last_ff;
   logic                     s1_advance;

   // running crc, right aligned
   logic [MAX_CRC_WIDTH-1:0] running_crc_ff;
   logic [MAX_CRC_WIDTH-1:0] running_crc_in;

   // result register
   logic                     rsp_valid_ff;
   logic [MAX_CRC_WIDTH-1:0] rsp_crc_ff;
   logic [MAX_CRC_WIDTH-1:0] rsp_crc_in;

   // fold datapath
   logic [WB-1:0]            eff_width;
   logic [WB-1:0]            shift_full;
   logic [SHIFT_BITS-1:0]    shift_amt;
   logic [MAX_CRC_WIDTH-1:0] width_mask;
   logic [MAX_CRC_WIDTH-1:0] poly_aligned;
   logic [MAX_CRC_WIDTH-1:0] crc_aligned;
   logic [MAX_CRC_WIDTH-1:0] crc_reversed;
   logic [NB-1:0]            byte_in;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_width_ff     <= crc_pkg::RESET_CRC_WIDTH;
         polynomial_ff    <= crc_pkg::RESET_POLYNOMIAL[MAX_CRC_WIDTH-1:0];
         initial_value_ff <= crc_pkg::RESET_INITIAL_VALUE[MAX_CRC_WIDTH-1:0];
         final_xor_ff     <= crc_pkg::RESET_FINAL_XOR[MAX_CRC_WIDTH-1:0];
         reflect_mode_ff  <= crc_pkg::RESET_REFLECT_MODE;
      end else if (csr_write_enable) begin
         case (csr_index)
            crc_pkg::CSR_CRC_WIDTH:     crc_width_ff     <= csr_write_data[WB-1:0];
            crc_pkg::CSR_POLYNOMIAL:    polynomial_ff    <= csr_write_data[MAX_CRC_WIDTH-1:0];
            crc_pkg::CSR_INITIAL_VALUE: initial_value_ff <= csr_write_data[MAX_CRC_WIDTH-1:0];
            crc_pkg::CSR_FINAL_XOR:     final_xor_ff     <= csr_write_data[MAX_CRC_WIDTH-1:0];
            crc_pkg::CSR_REFLECT_MODE:  reflect_mode_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // request register moves on unless its result has nowhere to go
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_data_ff  <= req.data_byte;
         s1_first_ff <= req.first_byte;
         s1_last_ff  <= req.last_byte;
      end
   end

   // clamp the width and derive the left-align shift
   always_comb begin
      eff_width = crc_width_ff;
      if (crc_width_ff < MIN_W) eff_width = MIN_W;
      if (crc_width_ff > MAX_W) eff_width = MAX_W;
      shift_full   = MAX_W - eff_width;
      shift_amt    = shift_full[SHIFT_BITS-1:0];
      width_mask   = {MAX_CRC_WIDTH{1'b1}} >> shift_amt;
      poly_aligned = polynomial_ff << shift_amt;
   end

   // byte fold on the left-aligned register: top bit is always the msb
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         byte_in[i] = reflect_mode_ff ? s1_data_ff[NB-1-i] : s1_data_ff[i];
      end
      crc_aligned = (s1_first_ff ? initial_value_ff : running_crc_ff) << shift_amt;
      crc_aligned[MAX_CRC_WIDTH-1 -: NB] = crc_aligned[MAX_CRC_WIDTH-1 -: NB] ^ byte_in;
      for (int k = 0; k < NB; k++) begin
         if (crc_aligned[MAX_CRC_WIDTH-1]) begin
            crc_aligned = (crc_aligned << 1) ^ poly_aligned;
         end else begin
            crc_aligned = crc_aligned << 1;
         end
      end
      running_crc_in = crc_aligned >> shift_amt;
      // reversing the aligned word lands the reflected crc in the low bits
      for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
         crc_reversed[i] = crc_aligned[MAX_CRC_WIDTH-1-i];
      end
      rsp_crc_in = (reflect_mode_ff ? crc_reversed : running_crc_in) ^
                   (final_xor_ff & width_mask);
   end

   // running crc carries across results
   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= '0;
      end else if (s1_advance) begin
         running_crc_ff <= running_crc_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_crc_ff <= rsp_crc_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.crc_result = rsp_crc_ff;

   // a byte that makes no result never waits on the response side
   a_no_result_no_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_last_ff |-> s1_advance)
      else $error("non-final byte stalled in request register");

   // a new result only comes from a final byte leaving the request register
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(s1_advance && s1_last_ff))
      else $error("result appeared without a final byte");

   // an empty request register always takes a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("empty request register not ready");

   // a waiting result that is not taken stays
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_crc_ff))
      else $error("pending result lost");

endmodule

`default_nettype wire

// ===== test/crc_checker.sv =====
// crc result checker: mirrors the crc engine's register and configuration to predict results
// depends on crc_pkg and the crc_req_if / crc_rsp_if channel interfaces
`timescale 1ns / 100ps

module crc_checker import crc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   crc_req_if                         req,
   crc_rsp_if                         rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         outstanding,
   output int                         error_count,
   output int                         results_checked
);

   // mirrored configuration and running register
   logic [CRC_WIDTH_BITS-1:0] width_setting;
   logic [MAX_CRC_WIDTH-1:0]  poly_setting;
   logic [MAX_CRC_WIDTH-1:0]  init_setting;
   logic [MAX_CRC_WIDTH-1:0]  xor_setting;
   logic                      reflect_setting;
   logic [MAX_CRC_WIDTH-1:0]  crc_register;

   // finished crcs waiting for the response channel, oldest first
   logic [MAX_CRC_WIDTH-1:0]  crc_due[$];

   // bit-reverse the low n bits
   function automatic logic [MAX_CRC_WIDTH-1:0] reverse_low(
      input logic [MAX_CRC_WIDTH-1:0] value, input int n);
      logic [MAX_CRC_WIDTH-1:0] flipped;
      flipped = '0;
      for (int i = 0; i < n; i++) flipped[n-1-i] = value[i];
      return flipped;
   endfunction

   // fold one request byte into the register, queue the crc on a message end
   function automatic void fold_request(input logic [BYTE_BITS-1:0] data,
                                        input logic first, input logic last);
      int                       w;
      logic [MAX_CRC_WIDTH-1:0] mask;
      logic [MAX_CRC_WIDTH-1:0] crc;
      logic [MAX_CRC_WIDTH-1:0] folded_byte;
      logic                     msb;
      // out-of-range widths clamp to the supported span
      w = int'(width_setting);
      if (w < MIN_CRC_WIDTH) w = MIN_CRC_WIDTH;
      if (w > MAX_CRC_WIDTH) w = MAX_CRC_WIDTH;
      mask = (w >= MAX_CRC_WIDTH) ? '1 : ((64'd1 << w) - 64'd1);
      crc = (first ? init_setting : crc_register) & mask;
      folded_byte = '0;
      folded_byte[BYTE_BITS-1:0] = data;
      if (reflect_setting) folded_byte = reverse_low(folded_byte, BYTE_BITS);
      crc ^= folded_byte << (w - BYTE_BITS);
      repeat (BYTE_BITS) begin
         msb = crc[w-1];
         crc = (crc << 1) & mask;
         if (msb) crc ^= poly_setting & mask;
      end
      crc_register = crc;
      if (last) begin
         if (reflect_setting) crc = reverse_low(crc, w);
         crc_due.push_back((crc ^ xor_setting) & mask);
      end
   endfunction

   always @(posedge clock) begin
      logic [MAX_CRC_WIDTH-1:0] crc_wanted;
      if (reset) begin
         width_setting   = RESET_CRC_WIDTH;
         poly_setting    = RESET_POLYNOMIAL;
         init_setting    = RESET_INITIAL_VALUE;
         xor_setting     = RESET_FINAL_XOR;
         reflect_setting = RESET_REFLECT_MODE;
         crc_register    = '0;
         crc_due.delete();
      end else begin
         // compare each delivered crc with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (crc_due.size() == 0) begin
               $error("crc_result: nothing expected, actual %h", rsp.crc_result);
               error_count++;
            end else begin
               crc_wanted = crc_due.pop_front();
               results_checked++;
               if (rsp.crc_result !== crc_wanted) begin
                  $error("crc_result mismatch: expected %h, actual %h",
                         crc_wanted, rsp.crc_result);
                  error_count++;
               end
            end
         end
         // accepted request bytes
         if (req.valid && req.ready)
            fold_request(req.data_byte, req.first_byte, req.last_byte);
         // register writes; unused indexes are ignored
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_CRC_WIDTH:     width_setting   = csr_write_data[CRC_WIDTH_BITS-1:0];
               CSR_POLYNOMIAL:    poly_setting    = csr_write_data;
               CSR_INITIAL_VALUE: init_setting    = csr_write_data;
               CSR_FINAL_XOR:     xor_setting     = csr_write_data;
               CSR_REFLECT_MODE:  reflect_setting = csr_write_data[0];
               default: ;
            endcase
         end
      end
      outstanding <= crc_due.size();
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the crc engine: clock, reset, register settings, request and response traffic
// depends on crc_pkg, the channel interfaces, parameterized_crc_engine and crc_checker
`timescale 1ns / 100ps

module tb_top;
   import crc_pkg::*;

   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 175;
   localparam int RUN_LIMIT_NS = 2_000_000;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int outstanding;
   int error_count;
   int results_checked;
   int requests_sent = 0;
   int settings_used = 0;
   bit steady = 1'b0;

   crc_req_if req_ch ();
   crc_rsp_if rsp_ch ();

   parameterized_crc_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   crc_checker u_crc_check (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .outstanding      (outstanding),
      .error_count      (error_count),
      .results_checked  (results_checked)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop if the run hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_top: done, errors");
      $finish;
   end

   // response side: random stalls before each crc, none during steady stretches
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // one request byte, after a random gap; valid stays high for back-to-back bytes
   task automatic send_byte(input logic [BYTE_BITS-1:0] data, input logic first,
                            input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= data;
      req_ch.first_byte <= first;
      req_ch.last_byte  <= last;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   // well-formed message of random bytes
   task automatic send_message(input int length);
      for (int i = 0; i < length; i++)
         send_byte(BYTE_BITS'($urandom_range(0, 255)), i == 0, i == length - 1);
   endtask

   // wait for every crc to arrive and the fold pipeline to empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // program all five registers; width and reflect carry random upper bits
   task automatic write_settings(input logic [CRC_WIDTH_BITS-1:0] width,
                                 input logic [CSR_DATA_WIDTH-1:0] poly,
                                 input logic [CSR_DATA_WIDTH-1:0] init,
                                 input logic [CSR_DATA_WIDTH-1:0] final_mask,
                                 input logic reflect);
      logic [CSR_DATA_WIDTH-1:0] noise;
      noise = {$urandom, $urandom};
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CRC_WIDTH;
      csr_write_data   <= {noise[CSR_DATA_WIDTH-1:CRC_WIDTH_BITS], width};
      @(posedge clock);
      csr_index        <= CSR_POLYNOMIAL;
      csr_write_data   <= poly;
      @(posedge clock);
      csr_index        <= CSR_INITIAL_VALUE;
      csr_write_data   <= init;
      @(posedge clock);
      csr_index        <= CSR_FINAL_XOR;
      csr_write_data   <= final_mask;
      @(posedge clock);
      csr_index        <= CSR_REFLECT_MODE;
      csr_write_data   <= {noise[CSR_DATA_WIDTH-1:1], reflect};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // wide register value: zero, all ones or random
   function automatic logic [CSR_DATA_WIDTH-1:0] random_wide();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // width draw biased toward the edges and the clamped ranges
   function automatic logic [CRC_WIDTH_BITS-1:0] random_width();
      case ($urandom_range(0, 9))
         0:       return CRC_WIDTH_BITS'(MIN_CRC_WIDTH);
         1:       return CRC_WIDTH_BITS'(MAX_CRC_WIDTH);
         2:       return CRC_WIDTH_BITS'($urandom_range(0, MIN_CRC_WIDTH - 1));
         3:       return CRC_WIDTH_BITS'($urandom_range(MAX_CRC_WIDTH + 1,
                                                        (1 << CRC_WIDTH_BITS) - 1));
         default: return CRC_WIDTH_BITS'($urandom_range(MIN_CRC_WIDTH + 1,
                                                        MAX_CRC_WIDTH - 1));
      endcase
   endfunction

   initial begin
      string check_text;
      int    phase_start;
      int    length;
      check_text = "123456789";

      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.first_byte <= 1'b0;
      req_ch.last_byte  <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_CRC_WIDTH;
      csr_write_data    <= '0;
      reset             <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // writes to unused indexes must leave the reset settings alone
      for (int idx = CSR_REFLECT_MODE + 1; idx < (1 << CSR_INDEX_WIDTH); idx++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_INDEX_WIDTH'(idx);
         csr_write_data   <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;

      // directed: bytes with no message start continue the zero register after reset
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b1);
      // standard check string under the reset crc-32 settings
      for (int i = 0; i < check_text.len(); i++)
         send_byte(check_text[i], i == 0, i == check_text.len() - 1);
      // first and last in one byte, byte extremes
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      // continuing after a result without a new start
      send_byte(8'h5A, 1'b0, 1'b1);
      // restart in the middle of a message
      send_byte(8'h81, 1'b1, 1'b0);
      send_byte(8'h7E, 1'b1, 1'b1);
      settle();

      // random phases, each under its own register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_settings(CRC_WIDTH_BITS'(MIN_CRC_WIDTH), '1, '0, '0, 1'b0);
            1: write_settings(CRC_WIDTH_BITS'(MAX_CRC_WIDTH), random_wide(), '1, '1, 1'b1);
            2: write_settings(CRC_WIDTH_BITS'($urandom_range(0, MIN_CRC_WIDTH - 1)),
                              random_wide(), random_wide(), random_wide(),
                              1'($urandom_range(0, 1)));
            3: write_settings('1, random_wide(), random_wide(), random_wide(),
                              1'($urandom_range(0, 1)));
            default: write_settings(random_width(), random_wide(), random_wide(),
                                    random_wide(), 1'($urandom_range(0, 1)));
         endcase
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8) begin
               length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
               send_message(length);
            end else begin
               // stray bytes with random start and end flags
               repeat ($urandom_range(1, 4))
                  send_byte(BYTE_BITS'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
         steady = 1'b0;
         settle();
      end

      $display("tb_top: %0d request bytes sent, %0d crc results checked", requests_sent,
               results_checked);
      $display("tb_top: %0d register settings, widths clamped low and high included",
               settings_used + 1);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== parameterized_crc_engine.f =====
hdl/crc_pkg.sv
hdl/crc_if.sv
hdl/parameterized_crc_engine.sv
test/crc_checker.sv
test/tb_top.sv
